/* sv/shs_pkg.sv */
// Package for the Swiss hash table engine.
// Holds the job and result types and the fixed hashing constants.
// No dependencies.
`default_nettype none

package shs_pkg;

    // Multiplier of the key hash.
    localparam logic [63:0] HASH_MULT  = 64'h517cc1b727220a95;
    // Control byte of an empty bucket; a full bucket holds its tag with bit 7 clear.
    localparam logic [7:0]  CTRL_EMPTY = 8'hFF;
    localparam int          FREE_BIT   = 7;
    localparam int          TAG_W      = 7;
    localparam int          SLOT_W     = 10;

    // Request command codes.
    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // One hashed request handed from the front end to the probe engine.
    typedef struct packed {
        logic             cmd;
        logic [63:0]      key;
        logic [31:0]      hash_lo;
        logic [TAG_W-1:0] tag;
    } t_job;

    // One response beat.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic              placed;
        logic              table_full;
    } t_result;

endpackage

`default_nettype wire

/* sv/shs_if.sv */
// Valid/ready channel interfaces of the Swiss hash table engine.
// Request and response beats; depends on nothing.
`default_nettype none

interface shs_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface shs_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [9:0] slot;
    logic       placed;
    logic       table_full;

    modport source (output valid, output found, output slot, output placed,
                    output table_full, input ready);
    modport sink   (input valid, input found, input slot, input placed,
                    input table_full, output ready);
endinterface

`default_nettype wire

/* sv/shs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module shs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/shs_front.sv */
// Front end: accepts request beats and hashes the key with one shared
// 32x32 multiplier in MUL0, MUL1, MUL2. Depends on shs_pkg and shs_if.
`default_nettype none

module shs_front
    import shs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_enable,
    shs_req_if.sink    i_req,
    output logic       o_push,
    output t_job       o_job,
    input  wire logic  i_full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL0 = 5'b00010,
        F_MUL1 = 5'b00100,
        F_MUL2 = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate     r_state, n_state;
    logic        r_cmd;
    logic [63:0] r_key;
    logic [31:0] r_lo;
    logic [31:0] r_acc;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    assign i_req.ready = (r_state == F_IDLE) && i_enable;
    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_job       = '{cmd: r_cmd, key: r_key, hash_lo: r_lo, tag: r_acc[31:25]};

    // Operand selection for the shared multiplier: lo*lo, lo*hi, hi*lo.
    always_comb begin
        mul_a = r_key[31:0];
        mul_b = HASH_MULT[31:0];
        case (r_state)
            F_MUL1: begin
                mul_b = HASH_MULT[63:32];
            end
            F_MUL2: begin
                mul_a = r_key[63:32];
            end
            default: begin
            end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // Sequencing of one request.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_req.valid && i_req.ready) n_state = F_MUL0;
            F_MUL0: n_state = F_MUL1;
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers: the key and the partial sums of the upper hash word.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    r_cmd <= i_req.cmd;
                    r_key <= i_req.key;
                end
            end
            F_MUL0: begin
                r_lo  <= prod[31:0];
                r_acc <= prod[63:32];
            end
            F_MUL1, F_MUL2: begin
                r_acc <= r_acc + prod[31:0];
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/shs_queue.sv */
// Two-entry job queue between the front end and the probe engine.
// Depends on shs_pkg.
`default_nettype none

module shs_queue
    import shs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* sv/shs_back.sv */
// Probe engine: clears the control store, walks probe windows slot by slot,
// places new keys and holds the response register.
// Depends on shs_pkg, shs_if and shs_ram.
`default_nettype none

module shs_back
    import shs_pkg::*;
#(
    parameter int BUCKETS    = 1024,
    parameter int GROUP_SIZE = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_ready,
    shs_rsp_if.source o_rsp
);

    localparam int IW = $clog2(BUCKETS);
    localparam int CW = $clog2(BUCKETS + 1);
    localparam int GW = $clog2(GROUP_SIZE);

    typedef enum logic [4:0] {
        B_CLEAR = 5'b00001,
        B_IDLE  = 5'b00010,
        B_RD    = 5'b00100,
        B_CHK   = 5'b01000,
        B_DONE  = 5'b10000
    } t_bstate;

    t_bstate       r_state;
    logic [IW-1:0] r_clr;
    t_job          r_job;
    logic [IW-1:0] r_base, r_step, r_free;
    logic [CW-1:0] r_win;
    logic [GW-1:0] r_idx;
    logic          r_saw_empty, r_have_free;
    logic [CW-1:0] r_budget;
    t_result       r_pend, r_res, n_pend;
    logic          r_out_valid;

    logic [IW-1:0] p, fp;
    logic [31:0]   fp32;
    logic [7:0]    ctrl_rd, ctrl_wd;
    logic [63:0]   key_rd;
    logic          ctrl_we, key_we;
    logic [IW-1:0] waddr;
    logic          hit, empty_now, win_empty, last_slot, last_win, have_free;
    logic          finish, place;
    logic          out_free;

    assign p        = r_base + IW'(r_idx);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign o_ready  = (r_state != B_CLEAR);
    assign o_pop    = (r_state == B_IDLE) && i_job_valid;

    // Slot checks on the control byte and key read back for slot p.
    assign hit       = (ctrl_rd == {1'b0, r_job.tag}) && (key_rd == r_job.key);
    assign empty_now = (ctrl_rd == CTRL_EMPTY);
    assign win_empty = r_saw_empty || empty_now;
    assign last_slot = (r_idx == GW'(GROUP_SIZE - 1));
    assign last_win  = (r_win == CW'(BUCKETS - 1));
    assign have_free = r_have_free || ctrl_rd[FREE_BIT];
    assign fp        = r_have_free ? r_free : p;
    assign fp32      = 32'(fp);
    assign finish    = (r_state == B_CHK) && (hit || (last_slot && (win_empty || last_win)));
    assign place     = finish && !hit && (r_job.cmd == CMD_INSERT) &&
                       (r_budget != '0) && have_free;

    // Response of a finished probe.
    always_comb begin
        n_pend = '0;
        if (hit) begin
            n_pend.found = 1'b1;
            n_pend.slot  = SLOT_W'(32'(p));
        end else if (place) begin
            n_pend.placed = 1'b1;
            n_pend.slot   = fp32[SLOT_W-1:0];
        end else if (r_job.cmd == CMD_INSERT) begin
            n_pend.table_full = 1'b1;
        end
    end

    // Write port: the clearing pass, then placements.
    assign ctrl_we = (r_state == B_CLEAR) || place;
    assign key_we  = place;
    assign waddr   = (r_state == B_CLEAR) ? r_clr : fp;
    assign ctrl_wd = (r_state == B_CLEAR) ? CTRL_EMPTY : {1'b0, r_job.tag};

    shs_ram #(.WIDTH(8), .DEPTH(BUCKETS)) u_ctrl (
        .i_clk   (i_clk),
        .i_we    (ctrl_we),
        .i_waddr (waddr),
        .i_wdata (ctrl_wd),
        .i_raddr (p),
        .o_rdata (ctrl_rd)
    );

    shs_ram #(.WIDTH(64), .DEPTH(BUCKETS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (fp),
        .i_wdata (r_job.key),
        .i_raddr (p),
        .o_rdata (key_rd)
    );

    // Control state of the probe walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_budget    <= CW'(BUCKETS / 8 * 7);
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == B_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + IW'(1);
                    if (r_clr == IW'(BUCKETS - 1)) r_state <= B_IDLE;
                end
                B_IDLE: begin
                    if (i_job_valid) r_state <= B_RD;
                end
                B_RD: begin
                    r_state <= B_CHK;
                end
                B_CHK: begin
                    if (place) r_budget <= r_budget - CW'(1);
                    r_state <= finish ? B_DONE : B_RD;
                end
                B_DONE: begin
                    if (out_free) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Probe position and job payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job       <= i_job;
                r_base      <= i_job.hash_lo[IW-1:0];
                r_step      <= '0;
                r_win       <= '0;
                r_idx       <= '0;
                r_saw_empty <= 1'b0;
                r_have_free <= 1'b0;
            end
            B_CHK: begin
                r_pend <= n_pend;
                if (!r_have_free && ctrl_rd[FREE_BIT]) begin
                    r_have_free <= 1'b1;
                    r_free      <= p;
                end
                if (last_slot) begin
                    r_idx       <= '0;
                    r_step      <= r_step + IW'(1);
                    r_base      <= r_base + IW'((r_step + IW'(1)) * IW'(GROUP_SIZE));
                    r_win       <= r_win + CW'(1);
                    r_saw_empty <= 1'b0;
                end else begin
                    r_idx       <= r_idx + GW'(1);
                    r_saw_empty <= win_empty;
                end
            end
            B_DONE: begin
                if (out_free) r_res <= r_pend;
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.found      = r_res.found;
    assign o_rsp.slot       = r_res.slot;
    assign o_rsp.placed     = r_res.placed;
    assign o_rsp.table_full = r_res.table_full;

`ifndef SYNTHESIS
    // A response carries at most one of found, placed and table_full.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_res.found, r_res.placed, r_res.table_full}) <= 1)
        else $error("response carries more than one outcome");

    // The budget only drops, by one, after a placement check.
    a_budget_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_budget != $past(r_budget)) |->
            ($past(r_state == B_CHK) && (r_budget == $past(r_budget) - CW'(1))))
        else $error("growth budget moved outside a placement");

    // No job leaves the queue while the control store is being cleared.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == B_IDLE))
        else $error("job popped outside idle");

    // The key store is only written together with a tag.
    a_key_with_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_we |-> (ctrl_we && (r_state == B_CHK)))
        else $error("key written without its control byte");
`endif

endmodule

`default_nettype wire

/* sv/swiss_hash_table_engine.sv */
// Top level of the Swiss hash table engine: front end, job queue, probe engine.
// Depends on shs_pkg, shs_if, shs_front, shs_queue, shs_back and shs_ram.
//
//   channel  dir  payload                               
//   i_req    in   cmd, key                              
//   o_rsp    out  found, slot, placed, table_full       
//
// Hashing runs in the front end through one shared 32x32 multiplier.
// The probe engine handles each slot in a RAM address and registered read state,
// then in a compare state.
// After reset a clearing pass writes EMPTY over the whole control store; no request
// is taken until it ends. Each side stalls on its own.
`default_nettype none

module swiss_hash_table_engine
    import shs_pkg::*;
#(
    parameter int BUCKETS    = 1024,
    parameter int GROUP_SIZE = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    shs_req_if.sink   i_req,
    shs_rsp_if.source o_rsp
);

    logic push, full, pop, q_valid, back_ready;
    t_job f_job, q_job;

    shs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_enable (back_ready),
        .i_req    (i_req),
        .o_push   (push),
        .o_job    (f_job),
        .i_full   (full)
    );

    shs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    shs_back #(.BUCKETS(BUCKETS), .GROUP_SIZE(GROUP_SIZE)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_ready     (back_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
